/* sv/rpbu_pkg.sv */
// Shared opcodes, register indexes and types for the RGB pixel blend unit.
package rpbu_pkg;

    localparam int CH_W     = 8;
    localparam int OP_W     = 3;
    localparam int SEL_W    = 2;
    localparam int PROD_W   = 2 * CH_W;
    localparam int NUM_LANE = 3;
    localparam int ADDR_W   = 4;
    localparam int APB_W    = 32;

    localparam logic [OP_W-1:0] OP_MUL   = 3'd0;
    localparam logic [OP_W-1:0] OP_SCRN  = 3'd1;
    localparam logic [OP_W-1:0] OP_SUB   = 3'd2;
    localparam logic [OP_W-1:0] OP_ADD   = 3'd3;
    localparam logic [OP_W-1:0] OP_OVL   = 3'd4;
    localparam logic [OP_W-1:0] OP_ADDS  = 3'd5;
    localparam logic [OP_W-1:0] OP_MULS  = 3'd6;
    localparam logic [OP_W-1:0] OP_SEP   = 3'd7;

    localparam logic [1:0] REG_SCL_BLUE  = 2'd0;
    localparam logic [1:0] REG_SCL_GREEN = 2'd1;
    localparam logic [1:0] REG_SCL_RED   = 2'd2;
    localparam logic [1:0] REG_CHAN_SEL  = 2'd3;

    localparam logic [SEL_W-1:0] CH_BLUE  = 2'd0;
    localparam logic [SEL_W-1:0] CH_GREEN = 2'd1;

    localparam int LANE_BLUE  = 0;
    localparam int LANE_GREEN = 1;
    localparam int LANE_RED   = 2;

    localparam logic [1:0] KIND_PLAIN = 2'd0;
    localparam logic [1:0] KIND_DIV   = 2'd1;
    localparam logic [1:0] KIND_SAT   = 2'd2;

    localparam logic [CH_W-1:0] CH_MAX   = 8'd255;
    localparam logic [CH_W-1:0] OVL_HALF = 8'd127;
    localparam logic [CH_W-1:0] CEIL_ADJ = 8'd254;

    typedef logic [CH_W-1:0] t_chan;

    typedef struct packed {
        logic              valid;
        logic              separate;
        logic [SEL_W-1:0]  sel;
    } t_ctrl;

endpackage

/* sv/rpbu_lane.sv */
// One color channel lane: operand select and multiply, then divide by 255 and mode select.
module rpbu_lane
    import rpbu_pkg::*;
(
    input  logic             i_clk,
    input  logic [OP_W-1:0]  i_opcode,
    input  t_chan            i_a,
    input  t_chan            i_b,
    input  t_chan            i_scalar,
    output t_chan            o_result
);

    logic [CH_W-1:0]   ia;
    logic [CH_W-1:0]   ib;
    logic [CH_W-1:0]   ma;
    logic [CH_W-1:0]   mb;
    logic [CH_W:0]     sum_ab;
    logic [CH_W:0]     sum_as;
    logic [1:0]        n_kind;
    logic              n_dbl;
    logic              n_ceil;
    logic [CH_W-1:0]   n_plain;

    logic [PROD_W-1:0] r_prod;
    logic [1:0]        r_kind;
    logic              r_dbl;
    logic              r_ceil;
    logic [CH_W-1:0]   r_plain;

    logic [PROD_W:0]   x;
    logic [CH_W:0]     hi;
    logic [CH_W+1:0]   hl;
    logic [CH_W:0]     q;
    logic [CH_W-1:0]   div_res;

    assign ia     = ~i_a;
    assign ib     = ~i_b;
    assign sum_ab = {1'b0, i_a} + {1'b0, i_b};
    assign sum_as = {1'b0, i_a} + {1'b0, i_scalar};

    always_comb begin
        ma      = i_a;
        mb      = i_b;
        n_kind  = KIND_PLAIN;
        n_dbl   = 1'b0;
        n_ceil  = 1'b0;
        n_plain = i_a;
        case (i_opcode)
            OP_MUL: begin
                n_kind = KIND_DIV;
            end
            OP_SCRN: begin
                ma     = ia;
                mb     = ib;
                n_kind = KIND_DIV;
                n_ceil = 1'b1;
            end
            OP_SUB: begin
                n_plain = (i_a < i_b) ? '0 : i_a - i_b;
            end
            OP_ADD: begin
                n_plain = sum_ab[CH_W] ? CH_MAX : sum_ab[CH_W-1:0];
            end
            OP_OVL: begin
                n_kind = KIND_DIV;
                n_dbl  = 1'b1;
                if (i_b > OVL_HALF) begin
                    ma     = ia;
                    mb     = ib;
                    n_ceil = 1'b1;
                end
            end
            OP_ADDS: begin
                n_plain = sum_as[CH_W] ? CH_MAX : sum_as[CH_W-1:0];
            end
            OP_MULS: begin
                mb     = i_scalar;
                n_kind = KIND_SAT;
            end
            default: begin
                n_plain = i_a;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod  <= {{CH_W{1'b0}}, ma} * {{CH_W{1'b0}}, mb};
        r_kind  <= n_kind;
        r_dbl   <= n_dbl;
        r_ceil  <= n_ceil;
        r_plain <= n_plain;
    end

    // x = 255*hi + (hi + lo), so the quotient is hi plus at most two
    always_comb begin
        x = r_dbl ? {r_prod, 1'b0} : {1'b0, r_prod};
        if (r_ceil) begin
            x = x + {{(PROD_W+1-CH_W){1'b0}}, CEIL_ADJ};
        end
        hi = x[PROD_W:CH_W];
        hl = {1'b0, hi} + {2'b00, x[CH_W-1:0]};
        if (hl >= {1'b0, CH_MAX, 1'b0}) begin
            q = hi + 9'd2;
        end else if (hl >= {2'b00, CH_MAX}) begin
            q = hi + 9'd1;
        end else begin
            q = hi;
        end
        div_res = r_ceil ? CH_MAX - q[CH_W-1:0] : q[CH_W-1:0];
    end

    always_comb begin
        case (r_kind)
            KIND_DIV: o_result = div_res;
            KIND_SAT: o_result = (r_prod > {{CH_W{1'b0}}, CH_MAX}) ? CH_MAX
                                                                   : r_prod[CH_W-1:0];
            default:  o_result = r_plain;
        endcase
    end

endmodule

/* sv/rpbu_merge.sv */
// Merge stage: gather the lane results, apply channel separate, register the output.
module rpbu_merge
    import rpbu_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_ctrl  i_ctrl,
    input  t_chan  i_lane [NUM_LANE],
    output logic   o_valid,
    output t_chan  o_out [NUM_LANE]
);

    logic  r_valid;
    t_chan r_out [NUM_LANE];
    t_chan pick;

    always_comb begin
        case (i_ctrl.sel)
            CH_BLUE:  pick = i_lane[LANE_BLUE];
            CH_GREEN: pick = i_lane[LANE_GREEN];
            default:  pick = i_lane[LANE_RED];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_ctrl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NUM_LANE; k++) begin
            r_out[k] <= i_ctrl.separate ? pick : i_lane[k];
        end
    end

    assign o_valid = r_valid;
    assign o_out   = r_out;

endmodule

/* sv/rgb_pixel_blend_unit.sv */
// Top level of the RGB pixel blend unit: APB registers, lane array and merge stage.
// One pixel pair is taken per clock: busy stays low, so a request can be issued on
// every cycle. Each request yields exactly one blended pixel on o_valid, registered in
// the lane multiply stage and, after divide-by-255, in the merge stage; o_valid lasts
// one cycle and the receiver must take it then. The user must write the scalar and
// channel-select registers via APB only while no request is in flight (not enforced).
module rgb_pixel_blend_unit
    import rpbu_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [APB_W-1:0]  pwdata,
    output logic [APB_W-1:0]  prdata,
    output logic              pready,
    input  logic              start,
    output logic              busy,
    input  logic [OP_W-1:0]   i_opcode,
    input  logic [CH_W-1:0]   i_a_blue,
    input  logic [CH_W-1:0]   i_a_green,
    input  logic [CH_W-1:0]   i_a_red,
    input  logic [CH_W-1:0]   i_b_blue,
    input  logic [CH_W-1:0]   i_b_green,
    input  logic [CH_W-1:0]   i_b_red,
    output logic              o_valid,
    output logic [CH_W-1:0]   o_out_blue,
    output logic [CH_W-1:0]   o_out_green,
    output logic [CH_W-1:0]   o_out_red
);

    logic [CH_W-1:0]  r_scl_blue;
    logic [CH_W-1:0]  r_scl_green;
    logic [CH_W-1:0]  r_scl_red;
    logic [SEL_W-1:0] r_chan_sel;
    logic             wr_en;
    logic [1:0]       reg_idx;

    t_ctrl r_ctrl;
    t_ctrl n_ctrl;
    t_chan a_vec   [NUM_LANE];
    t_chan b_vec   [NUM_LANE];
    t_chan s_vec   [NUM_LANE];
    t_chan lane_res [NUM_LANE];
    t_chan out_vec [NUM_LANE];

    assign pready  = 1'b1;
    assign busy    = 1'b0;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[ADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scl_blue  <= '0;
            r_scl_green <= '0;
            r_scl_red   <= '0;
            r_chan_sel  <= '0;
        end else if (wr_en) begin
            case (reg_idx)
                REG_SCL_BLUE:  r_scl_blue  <= pwdata[CH_W-1:0];
                REG_SCL_GREEN: r_scl_green <= pwdata[CH_W-1:0];
                REG_SCL_RED:   r_scl_red   <= pwdata[CH_W-1:0];
                default:       r_chan_sel  <= pwdata[SEL_W-1:0];
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_SCL_BLUE:  prdata = {{(APB_W-CH_W){1'b0}}, r_scl_blue};
            REG_SCL_GREEN: prdata = {{(APB_W-CH_W){1'b0}}, r_scl_green};
            REG_SCL_RED:   prdata = {{(APB_W-CH_W){1'b0}}, r_scl_red};
            default:       prdata = {{(APB_W-SEL_W){1'b0}}, r_chan_sel};
        endcase
    end

    assign a_vec[LANE_BLUE]  = i_a_blue;
    assign a_vec[LANE_GREEN] = i_a_green;
    assign a_vec[LANE_RED]   = i_a_red;
    assign b_vec[LANE_BLUE]  = i_b_blue;
    assign b_vec[LANE_GREEN] = i_b_green;
    assign b_vec[LANE_RED]   = i_b_red;
    assign s_vec[LANE_BLUE]  = r_scl_blue;
    assign s_vec[LANE_GREEN] = r_scl_green;
    assign s_vec[LANE_RED]   = r_scl_red;

    always_comb begin
        n_ctrl.valid    = start && !busy;
        n_ctrl.separate = (i_opcode == OP_SEP);
        n_ctrl.sel      = r_chan_sel;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl <= '0;
        end else begin
            r_ctrl <= n_ctrl;
        end
    end

    for (genvar g = 0; g < NUM_LANE; g++) begin : g_lane
        rpbu_lane u_lane (
            .i_clk    (i_clk),
            .i_opcode (i_opcode),
            .i_a      (a_vec[g]),
            .i_b      (b_vec[g]),
            .i_scalar (s_vec[g]),
            .o_result (lane_res[g])
        );
    end

    rpbu_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (r_ctrl),
        .i_lane  (lane_res),
        .o_valid (o_valid),
        .o_out   (out_vec)
    );

    assign o_out_blue  = out_vec[LANE_BLUE];
    assign o_out_green = out_vec[LANE_GREEN];
    assign o_out_red   = out_vec[LANE_RED];

`ifndef SYNTHESIS
    a_valid_from_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, 2))
        else $error("result strobe without a request two cycles earlier");

    a_start_to_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start ##2 $past(i_rst_n, 2) && $past(i_rst_n, 1) |-> o_valid)
        else $error("request produced no result");

    a_separate_equal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && $past(i_opcode, 2) == OP_SEP |->
            o_out_blue == o_out_green && o_out_green == o_out_red)
        else $error("separate mode channels differ");

    a_add_no_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && $past(i_opcode, 2) == OP_ADD |-> o_out_red >= $past(i_a_red, 2))
        else $error("add mode wrapped instead of saturating");

    a_sub_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && $past(i_opcode, 2) == OP_SUB |-> o_out_blue <= $past(i_a_blue, 2))
        else $error("subtract mode exceeded base channel");
`endif

endmodule

/* tb/rgb_pixel_blend_unit_tb.sv */
// Self-checking testbench for the RGB pixel blend unit: predictor, request log and stimulus.
package rpbu_tb_pkg;
    import rpbu_pkg::*;

    typedef logic [NUM_LANE-1:0][CH_W-1:0] t_pix;

    class blend_ledger;
        t_chan            scale [NUM_LANE] = '{default: '0};
        logic [SEL_W-1:0] chan_sel = '0;
        t_pix             pixels_due [$];
        int unsigned      errors = 0;
        int unsigned      checked = 0;
        int unsigned      op_count [8] = '{default: 0};

        function void set_reg(logic [1:0] idx, logic [APB_W-1:0] val);
            case (idx)
                REG_SCL_BLUE:  scale[LANE_BLUE]  = val[CH_W-1:0];
                REG_SCL_GREEN: scale[LANE_GREEN] = val[CH_W-1:0];
                REG_SCL_RED:   scale[LANE_RED]   = val[CH_W-1:0];
                REG_CHAN_SEL:  chan_sel          = val[SEL_W-1:0];
                default: ;
            endcase
        endfunction

        function t_pix blend_pixel(logic [OP_W-1:0] op, t_pix a, t_pix b);
            t_pix        res;
            int unsigned x, y, s, v;
            int          lane;
            if (op == OP_SEP) begin
                case (chan_sel)
                    CH_BLUE:  lane = LANE_BLUE;
                    CH_GREEN: lane = LANE_GREEN;
                    default:  lane = LANE_RED;
                endcase
                for (int k = 0; k < NUM_LANE; k++) res[k] = a[lane];
                return res;
            end
            for (int k = 0; k < NUM_LANE; k++) begin
                x = a[k];
                y = b[k];
                s = scale[k];
                case (op)
                    OP_MUL:  v = (x * y) / CH_MAX;
                    OP_SCRN: v = CH_MAX - ((CH_MAX - x) * (CH_MAX - y) + CEIL_ADJ) / CH_MAX;
                    OP_SUB:  v = (x < y) ? 0 : x - y;
                    OP_ADD:  v = x + y;
                    OP_OVL: begin
                        if (y <= OVL_HALF) v = (2 * x * y) / CH_MAX;
                        else v = CH_MAX - (2 * (CH_MAX - x) * (CH_MAX - y) + CEIL_ADJ) / CH_MAX;
                    end
                    OP_ADDS: v = x + s;
                    default: v = x * s;
                endcase
                res[k] = (v > CH_MAX) ? CH_MAX : t_chan'(v);
            end
            return res;
        endfunction

        function void log_request(logic [OP_W-1:0] op, t_pix a, t_pix b);
            pixels_due.push_back(blend_pixel(op, a, b));
            op_count[op]++;
        endfunction

        function void check_pixel(t_pix got);
            string lane_name [NUM_LANE];
            t_pix  want;
            lane_name[LANE_BLUE]  = "out_blue";
            lane_name[LANE_GREEN] = "out_green";
            lane_name[LANE_RED]   = "out_red";
            if (pixels_due.size() == 0) begin
                $error("blended pixel %h with no request pending", got);
                errors++;
                return;
            end
            want = pixels_due.pop_front();
            checked++;
            for (int k = 0; k < NUM_LANE; k++) begin
                if (got[k] !== want[k]) begin
                    $error("%s: expected %0d, actual %0d", lane_name[k], want[k], got[k]);
                    errors++;
                end
            end
        endfunction
    endclass
endpackage

module rgb_pixel_blend_unit_tb
    import rpbu_pkg::*;
    import rpbu_tb_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD = 10;
    localparam int IDLE_LIMIT = 2000;
    localparam int SETTLE     = 8;
    localparam int PHASE_ITEMS = 175;
    localparam logic [SEL_W-1:0] SEL_RED    = 2'd2;
    localparam logic [SEL_W-1:0] SEL_UNUSED = 2'd3;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [APB_W-1:0]  pwdata;
    logic [APB_W-1:0]  prdata;
    logic              pready;
    logic              start;
    logic              busy;
    logic [OP_W-1:0]   i_opcode;
    logic [CH_W-1:0]   i_a_blue, i_a_green, i_a_red;
    logic [CH_W-1:0]   i_b_blue, i_b_green, i_b_red;
    logic              o_valid;
    logic [CH_W-1:0]   o_out_blue, o_out_green, o_out_red;

    blend_ledger ledger;
    int          burst_left = 0;
    int          idle_cycles = 0;
    int          settings = 1;

    rgb_pixel_blend_unit u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .start      (start),
        .busy       (busy),
        .i_opcode   (i_opcode),
        .i_a_blue   (i_a_blue),
        .i_a_green  (i_a_green),
        .i_a_red    (i_a_red),
        .i_b_blue   (i_b_blue),
        .i_b_green  (i_b_green),
        .i_b_red    (i_b_red),
        .o_valid    (o_valid),
        .o_out_blue (o_out_blue),
        .o_out_green(o_out_green),
        .o_out_red  (o_out_red)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid) ledger.check_pixel({o_out_red, o_out_green, o_out_blue});
            if (start && !busy) begin
                ledger.log_request(i_opcode, {i_a_red, i_a_green, i_a_blue},
                                   {i_b_red, i_b_green, i_b_blue});
            end
            if (o_valid || (start && !busy)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("watchdog: no request or pixel for %0d cycles", IDLE_LIMIT);
                $display("rgb_pixel_blend_unit regression: fail");
                $finish;
            end
        end
    end

    function automatic t_chan rand_chan();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return CH_MAX;
            2:       return t_chan'($urandom_range(OVL_HALF - 1, OVL_HALF + 2));
            default: return t_chan'($urandom_range(0, CH_MAX));
        endcase
    endfunction

    task automatic send_pixel(input logic [OP_W-1:0] op, input t_pix a, input t_pix b);
        int gap;
        start     <= 1'b1;
        i_opcode  <= op;
        i_a_blue  <= a[LANE_BLUE];
        i_a_green <= a[LANE_GREEN];
        i_a_red   <= a[LANE_RED];
        i_b_blue  <= b[LANE_BLUE];
        i_b_green <= b[LANE_GREEN];
        i_b_red   <= b[LANE_RED];
        do @(posedge i_clk); while (busy);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        do @(posedge i_clk); while (ledger.pixels_due.size() != 0);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [CH_W-1:0] val);
        logic [APB_W-1:0] data;
        data           = $urandom;
        data[CH_W-1:0] = val;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        ledger.set_reg(idx, data);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_config(input t_chan blue, input t_chan green, input t_chan red,
                              input logic [SEL_W-1:0] sel);
        drain();
        write_reg(REG_SCL_BLUE, blue);
        write_reg(REG_SCL_GREEN, green);
        write_reg(REG_SCL_RED, red);
        write_reg(REG_CHAN_SEL, CH_W'(sel));
        settings++;
    endtask

    task automatic run_random(input int count);
        t_pix a, b;
        for (int n = 0; n < count; n++) begin
            for (int k = 0; k < NUM_LANE; k++) begin
                a[k] = rand_chan();
                b[k] = rand_chan();
            end
            send_pixel(OP_W'($urandom_range(0, OP_SEP)), a, b);
        end
    endtask

    initial begin
        ledger = new();
        i_rst_n   <= 1'b0;
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        paddr     <= '0;
        pwdata    <= '0;
        start     <= 1'b0;
        i_opcode  <= OP_MUL;
        i_a_blue  <= '0;
        i_a_green <= '0;
        i_a_red   <= '0;
        i_b_blue  <= '0;
        i_b_green <= '0;
        i_b_red   <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int k = 0; k <= OP_SEP; k++) begin
            send_pixel(OP_W'(k), {8'd128, 8'd255, 8'd0}, {8'd127, 8'd255, 8'd255});
            send_pixel(OP_W'(k), {8'd200, 8'd0, 8'd255}, {8'd128, 8'd128, 8'd0});
            send_pixel(OP_W'(k), {8'd255, 8'd255, 8'd255}, {8'd0, 8'd0, 8'd0});
        end
        run_random(PHASE_ITEMS);

        set_config(CH_MAX, CH_MAX, CH_MAX, SEL_RED);
        run_random(PHASE_ITEMS);
        set_config(8'd1, 8'd128, CEIL_ADJ, CH_GREEN);
        run_random(PHASE_ITEMS);
        set_config(rand_chan(), rand_chan(), rand_chan(), SEL_UNUSED);
        run_random(PHASE_ITEMS);
        set_config(rand_chan(), rand_chan(), rand_chan(), CH_BLUE);
        run_random(PHASE_ITEMS);
        set_config('0, CH_MAX, '0, SEL_W'($urandom_range(0, SEL_UNUSED)));
        run_random(PHASE_ITEMS);

        drain();
        repeat (SETTLE) @(posedge i_clk);
        if (ledger.pixels_due.size() != 0) begin
            $error("%0d blended pixels never came out", ledger.pixels_due.size());
            ledger.errors++;
        end
        $display("Checked %0d blended pixels over %0d register settings, %0d mismatches",
                 ledger.checked, settings, ledger.errors);
        $display({"Requests per opcode: mul %0d scrn %0d sub %0d add %0d ",
                  "ovl %0d adds %0d muls %0d sep %0d"},
                 ledger.op_count[OP_MUL], ledger.op_count[OP_SCRN], ledger.op_count[OP_SUB],
                 ledger.op_count[OP_ADD], ledger.op_count[OP_OVL], ledger.op_count[OP_ADDS],
                 ledger.op_count[OP_MULS], ledger.op_count[OP_SEP]);
        if (ledger.errors == 0) begin
            $display("rgb_pixel_blend_unit regression: pass");
        end else begin
            $display("rgb_pixel_blend_unit regression: fail");
        end
        $finish;
    end
endmodule

/* files.f */
sv/rpbu_pkg.sv
sv/rpbu_lane.sv
sv/rpbu_merge.sv
sv/rgb_pixel_blend_unit.sv
tb/rgb_pixel_blend_unit_tb.sv
